// ----- rtl/core/qph_pkg.sv -----
package qph_pkg;

    localparam int KEY_W     = 31;
    localparam int VAL_W     = 31;
    localparam int SIZE_W    = 11;
    localparam int CFG_W     = 31;
    localparam int DEPTH_DEF = 1024;

    localparam logic [SIZE_W-1:0] TS_RESET = SIZE_W'(1021);
    localparam logic [KEY_W-1:0]  KEY_EMPTY   = KEY_W'(0);
    localparam logic [KEY_W-1:0]  KEY_DELETED = KEY_W'(1);

    typedef enum logic [0:0] {
        CFG_TABLE_SIZE = 1'b0,
        CFG_NOT_FOUND  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISS      = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_BADKEY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CHECK,
        S_CLEAR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [VAL_W-1:0] value_res;
    } out_t;

    typedef struct packed {
        logic             key_we;
        logic             val_we;
        logic [KEY_W-1:0] key_wdata;
        logic [VAL_W-1:0] val_wdata;
    } st_req_t;

endpackage

// ----- rtl/core/qph_store.sv -----
module qph_store #(
    parameter int DEPTH = qph_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    aclk,
    input  logic [AW-1:0]           addr,
    input  qph_pkg::st_req_t        req,
    output logic [qph_pkg::KEY_W-1:0] key_rd,
    output logic [qph_pkg::VAL_W-1:0] val_rd
);
    import qph_pkg::*;

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [VAL_W-1:0] val_mem [DEPTH];
    logic [KEY_W-1:0] key_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;

    // single port each, read returns old contents on a same-cycle write
    always_ff @(posedge aclk) begin
        if (req.key_we) begin
            key_mem[addr] <= req.key_wdata;
        end
        key_rd_reg <= key_mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (req.val_we) begin
            val_mem[addr] <= req.val_wdata;
        end
        val_rd_reg <= val_mem[addr];
    end

    assign key_rd = key_rd_reg;
    assign val_rd = val_rd_reg;

endmodule

// ----- rtl/core/quadratic_probe_hash_map.sv -----
// Open-addressed hash map (quadratic probing) from 31-bit key to 31-bit value, one op per
// input word and one result word per op. After reset the block sweeps the key memory empty
// with s_ready low; config writes are taken during the sweep. A lookup runs a bit-serial
// remainder (key mod table size) through the one compare-subtract unit, then for each slot
// probed a registered memory read and then a check, and then hands off the result. Reserved
// keys go straight to the result; clear sweeps all DEPTH key words. A result word waiting on
// m_ready does not stop the next op from starting.
module quadratic_probe_hash_map #(
    parameter int DEPTH = qph_pkg::DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [0:0]                cfg_index,
    input  logic [qph_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  qph_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output qph_pkg::out_t             m_data
);
    import qph_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int TS_MAX = (1 << SIZE_W) - 1;
    localparam logic [SIZE_W-1:0] SIZE_CAP =
        (DEPTH < TS_MAX) ? SIZE_W'(DEPTH) : SIZE_W'(TS_MAX);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
    localparam logic [4:0]    DIV_LAST = 5'(KEY_W - 1);

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [KEY_W-1:0]    key_sh_reg, key_sh_next;
    logic [4:0]          div_cnt_reg, div_cnt_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SIZE_W-1:0]   pos_reg, pos_next;
    logic [SIZE_W-1:0]   off_reg, off_next;
    logic [SIZE_W-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]       clr_idx_reg, clr_idx_next;
    status_t             status_reg, status_next;
    logic [VAL_W-1:0]    res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_t                m_data_reg, m_data_next;
    logic [SIZE_W-1:0]   ts_reg;
    logic [VAL_W-1:0]    nfv_reg;

    logic [SIZE_W-1:0]   eff_size;
    logic [SIZE_W:0]     unit_a;
    logic [SIZE_W-1:0]   unit_y;
    logic [AW-1:0]       st_addr;
    st_req_t             st_req;
    logic [KEY_W-1:0]    key_rd;
    logic [VAL_W-1:0]    val_rd;
    logic                slot_stop;
    logic                slot_active;

    qph_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk   (aclk),
        .addr   (st_addr),
        .req    (st_req),
        .key_rd (key_rd),
        .val_rd (val_rd)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg  <= TS_RESET;
            nfv_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TABLE_SIZE: ts_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_NOT_FOUND:  nfv_reg <= cfg_wdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (ts_reg > SIZE_CAP) begin
            eff_size = SIZE_CAP;
        end else if (ts_reg == '0) begin
            eff_size = SIZE_W'(1);
        end else begin
            eff_size = ts_reg;
        end
    end

    // shared compare-subtract: operand stays below twice the table size for tables above one slot
    always_comb begin
        unique case (state_reg)
            S_DIV:   unit_a = {pos_reg, key_sh_reg[KEY_W-1]};
            S_READ:  unit_a = {1'b0, off_reg} + (SIZE_W+1)'(2);
            S_CHECK: unit_a = {1'b0, pos_reg} + {1'b0, off_reg};
            default: unit_a = '0;
        endcase
        if (unit_a >= {1'b0, size_reg}) begin
            unit_y = SIZE_W'(unit_a - {1'b0, size_reg});
        end else begin
            unit_y = unit_a[SIZE_W-1:0];
        end
    end

    assign slot_stop   = (key_rd == KEY_EMPTY) || (key_rd == key_reg);
    assign slot_active = (key_rd != KEY_EMPTY) && (key_rd != KEY_DELETED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        key_sh_reg  <= key_sh_next;
        div_cnt_reg <= div_cnt_next;
        size_reg    <= size_next;
        pos_reg     <= pos_next;
        off_reg     <= off_next;
        cnt_reg     <= cnt_next;
        status_reg  <= status_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        key_sh_next  = key_sh_reg;
        div_cnt_next = div_cnt_reg;
        size_next    = size_reg;
        pos_next     = pos_reg;
        off_next     = off_reg;
        cnt_next     = cnt_reg;
        clr_idx_next = clr_idx_reg;
        status_next  = status_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        st_addr      = AW'(pos_reg);
        st_req       = '{key_we: 1'b0, val_we: 1'b0, key_wdata: key_reg, val_wdata: val_reg};

        unique case (state_reg)
            S_INIT, S_CLEAR: begin
                st_addr          = clr_idx_reg;
                st_req.key_we    = 1'b1;
                st_req.key_wdata = KEY_EMPTY;
                clr_idx_next     = clr_idx_reg + AW'(1);
                if (clr_idx_reg == CLR_LAST) begin
                    clr_idx_next = '0;
                    state_next   = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next      = op_t'(s_data.op);
                    key_next     = s_data.key;
                    val_next     = s_data.value;
                    key_sh_next  = s_data.key;
                    size_next    = eff_size;
                    pos_next     = '0;
                    div_cnt_next = '0;
                    status_next  = ST_OK;
                    res_next     = (op_t'(s_data.op) == OP_FIND) ? nfv_reg : '0;
                    if (op_t'(s_data.op) == OP_CLEAR) begin
                        state_next = S_CLEAR;
                    end else if (s_data.key <= KEY_DELETED) begin
                        status_next = ST_BADKEY;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // one remainder bit per cycle, MSB first
                pos_next     = unit_y;
                key_sh_next  = {key_sh_reg[KEY_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == DIV_LAST) begin
                    off_next   = size_reg - SIZE_W'(1); // becomes 1 after first +2
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                off_next   = unit_y;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (slot_stop) begin
                    state_next = S_DONE;
                    unique case (op_reg)
                        OP_INSERT: begin
                            if (slot_active) begin
                                status_next = ST_PRESENT;
                            end else begin
                                st_req.key_we = 1'b1;
                                st_req.val_we = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (slot_active) begin
                                st_req.key_we    = 1'b1;
                                st_req.key_wdata = KEY_DELETED;
                            end else begin
                                status_next = ST_MISS;
                            end
                        end
                        OP_FIND: begin
                            if (slot_active) begin
                                res_next = val_rd;
                            end else begin
                                status_next = ST_MISS;
                            end
                        end
                        default: ;
                    endcase
                end else if (cnt_reg == size_reg - SIZE_W'(1)) begin
                    status_next = ST_EXHAUSTED;
                    state_next  = S_DONE;
                end else begin
                    pos_next   = unit_y;
                    cnt_next   = cnt_reg + SIZE_W'(1);
                    state_next = S_READ;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: status_reg, value_res: res_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_rem_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV || state_reg == S_READ || state_reg == S_CHECK)
        |-> (pos_reg < size_reg))
        else $error("probe position out of table range");

    // a one-slot table never steps, so its offset is don't-care
    a_off_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK && size_reg > SIZE_W'(1)) |-> (off_reg < size_reg))
        else $error("probe offset out of table range");

    a_check_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> ($past(state_reg) == S_READ))
        else $error("slot checked without a memory read");

    a_key_write_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_req.key_we && state_reg == S_CHECK)
        |-> (st_req.key_wdata == key_reg || st_req.key_wdata == KEY_DELETED))
        else $error("unexpected key word written");

    a_no_lost_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_ready) |=> (state_reg == S_DONE))
        else $error("result dropped while output busy");
`endif

endmodule
